// File: rtl/cscp_pkg.sv
// Shared types, codes and defaults of the call stack cycle profiler.
`default_nettype none
package cscp_pkg;
	localparam int STACK_DEPTH_DEF = 32;
	localparam int FUNC_SLOTS_DEF  = 64;

	localparam logic [1:0] EV_CALL  = 2'd0;
	localparam logic [1:0] EV_RET   = 2'd1;
	localparam logic [1:0] EV_FLUSH = 2'd2;

	localparam logic [2:0] ST_PUSHED    = 3'd0;
	localparam logic [2:0] ST_POPPED    = 3'd1;
	localparam logic [2:0] ST_MISALIGN  = 3'd2;
	localparam logic [2:0] ST_NOMATCH   = 3'd3;
	localparam logic [2:0] ST_OVERFLOW  = 3'd4;
	localparam logic [2:0] ST_TBL_FULL  = 3'd5;
	localparam logic [2:0] ST_EMPTY     = 3'd6;

	localparam logic [47:0] CYC_MAX = 48'hFFFF_FFFF_FFFF;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] cycle_stamp;
		logic [31:0] return_addr;
		logic [31:0] target_addr;
	} event_t;

	typedef struct packed {
		logic [31:0] popped_func_addr;
		logic [31:0] elapsed;
		logic [31:0] call_count;
		logic [47:0] total_cycles;
		logic [5:0]  slot;
		logic [2:0]  status;
		logic        time_clamped;
		logic        last;
		logic [5:0]  depth;
		logic [5:0]  max_depth;
		logic [31:0] total_calls;
		logic [31:0] covered_calls;
	} result_t;

	// request from the stack engine to the function table
	typedef struct packed {
		logic        valid;
		logic [31:0] func_addr;
		logic [31:0] elapsed;
		logic        clamped;
		logic [2:0]  status;
		logic        last;
	} charge_t;
endpackage
`default_nettype wire

// File: rtl/cscp_table.sv
// Function table: search, update or create one entry per closed frame.
`default_nettype none
module cscp_table #(
	parameter int FUNC_SLOTS = 64
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  cscp_pkg::charge_t   charge,
	output logic                done,
	output logic                res_valid,
	output logic [31:0]         res_calls,
	output logic [47:0]         res_cycles,
	output logic [5:0]          res_slot,
	output logic [2:0]          res_status,
	output logic                res_clamped,
	output logic                res_last,
	output logic [31:0]         res_func,
	output logic [31:0]         res_elapsed,
	output logic [31:0]         charged_q
);
	import cscp_pkg::*;
	localparam int SW = $clog2(FUNC_SLOTS);
	localparam int CW = $clog2(FUNC_SLOTS + 1);

	localparam logic [1:0] T_IDLE = 2'd0;
	localparam logic [1:0] T_SCAN = 2'd1;
	localparam logic [1:0] T_UPD  = 2'd2;

	logic [31:0] addr_mem [FUNC_SLOTS];
	logic [47:0] cyc_mem [FUNC_SLOTS];
	logic [31:0] cnt_mem [FUNC_SLOTS];

	logic [1:0]    state_q;
	logic [CW-1:0] used_q;
	logic [CW-1:0] idx_q;
	logic          rd_ok_q;
	logic [SW-1:0] rd_idx_q;
	logic [31:0]   addr_rd_q;
	logic [47:0]   cyc_rd_q;
	logic [31:0]   cnt_rd_q;
	charge_t       req_q;
	logic [SW-1:0] slot_q;
	logic          hit_q;
	logic [48:0]   sum;

	assign sum = {1'b0, cyc_rd_q} + {17'd0, req_q.elapsed};

	// one read port, one write port
	always_ff @(posedge clk) begin
		addr_rd_q <= addr_mem[idx_q[SW-1:0]];
		cyc_rd_q  <= cyc_mem[rd_idx_q];
		cnt_rd_q  <= cnt_mem[rd_idx_q];
		if (state_q == T_UPD) begin
			if (hit_q) begin
				cyc_mem[slot_q] <= sum[48] ? CYC_MAX : sum[47:0];
				cnt_mem[slot_q] <= cnt_rd_q + 32'd1;
			end else if (used_q < CW'(FUNC_SLOTS)) begin
				addr_mem[slot_q] <= req_q.func_addr;
				cyc_mem[slot_q]  <= {16'd0, req_q.elapsed};
				cnt_mem[slot_q]  <= 32'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= T_IDLE;
			used_q    <= '0;
			idx_q     <= '0;
			rd_ok_q   <= 1'b0;
			rd_idx_q  <= '0;
			charged_q <= '0;
			hit_q     <= 1'b0;
			slot_q    <= '0;
			res_valid <= 1'b0;
			done      <= 1'b0;
		end else begin
			res_valid <= state_q == T_UPD;
			done      <= state_q == T_UPD;
			case (state_q)
				T_IDLE: begin
					if (charge.valid) begin
						req_q   <= charge;
						idx_q   <= '0;
						rd_ok_q <= 1'b0;
						state_q <= T_SCAN;
					end
				end
				T_SCAN: begin
					// one entry per cycle, compare the previous read
					if (rd_ok_q && addr_rd_q == req_q.func_addr) begin
						hit_q   <= 1'b1;
						slot_q  <= rd_idx_q;
						state_q <= T_UPD;
					end else if (idx_q >= used_q || idx_q == CW'(FUNC_SLOTS)) begin
						hit_q   <= 1'b0;
						slot_q  <= used_q[SW-1:0];
						state_q <= T_UPD;
					end else begin
						rd_ok_q  <= 1'b1;
						rd_idx_q <= idx_q[SW-1:0];
						idx_q    <= idx_q + CW'(1);
					end
				end
				T_UPD: begin
					res_func    <= req_q.func_addr;
					res_elapsed <= req_q.elapsed;
					res_clamped <= req_q.clamped;
					res_last    <= req_q.last;
					if (hit_q) begin
						res_calls  <= cnt_rd_q + 32'd1;
						res_cycles <= sum[48] ? CYC_MAX : sum[47:0];
						res_slot   <= 6'(slot_q);
						res_status <= req_q.status;
						charged_q  <= charged_q + 32'd1;
					end else if (used_q < CW'(FUNC_SLOTS)) begin
						res_calls  <= 32'd1;
						res_cycles <= {16'd0, req_q.elapsed};
						res_slot   <= 6'(slot_q);
						res_status <= req_q.status;
						used_q     <= used_q + CW'(1);
						charged_q  <= charged_q + 32'd1;
					end else begin
						res_calls  <= '0;
						res_cycles <= '0;
						res_slot   <= '0;
						res_status <= ST_TBL_FULL;
					end
					state_q <= T_IDLE;
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: rtl/call_stack_cycle_profiler.sv
// Top level of the call stack cycle profiler: shadow stack engine and result port.
`default_nettype none
// A call or an empty flush shows its result from the S_ONE state; an ignored
// event kind leaves the engine idle. A return searches the stack top down, one
// frame per cycle; without a match the result is shown from S_ONE. Each closed
// frame then reads the top frame (S_RDTOP, S_CLOSE) and waits for the longer of
// the function table scan over the used table slots and, in exclusive mode, the
// start stamp adjustment of the remaining frames; the single read port stack
// memory and the single read port table set these steps. busy drops in the
// cycle that shows the last result of an event, or later if the start stamp
// adjustment is still running. Each result appears for one cycle with
// result_valid; the receiver cannot stall.
module call_stack_cycle_profiler #(
	parameter int STACK_DEPTH = cscp_pkg::STACK_DEPTH_DEF,
	parameter int FUNC_SLOTS  = cscp_pkg::FUNC_SLOTS_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  cscp_pkg::event_t   event_in,
	input  wire                cfg_we,
	input  wire                cfg_wdata,
	output logic               result_valid,
	output cscp_pkg::result_t  result
);
	import cscp_pkg::*;
	localparam int PW = $clog2(STACK_DEPTH);
	localparam int DW = $clog2(STACK_DEPTH + 1);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SRCH   = 3'd1;
	localparam logic [2:0] S_RDTOP  = 3'd2;
	localparam logic [2:0] S_CLOSE  = 3'd3;
	localparam logic [2:0] S_ADJ    = 3'd4;
	localparam logic [2:0] S_WAIT   = 3'd5;
	localparam logic [2:0] S_ONE    = 3'd6;

	logic [31:0] func_mem [STACK_DEPTH];
	logic [31:0] ret_mem [STACK_DEPTH];
	logic [31:0] start_mem [STACK_DEPTH];

	logic [2:0]    state_q;
	logic          mode_q;
	event_t        ev_q;
	logic [DW-1:0] sp_q;
	logic [DW-1:0] peak_q;
	logic [31:0]   calls_q;
	logic [DW-1:0] idx_q;      // search / adjust counter
	logic [PW-1:0] match_q;
	logic          rd_ok_q;
	logic [PW-1:0] rd_addr;
	logic [31:0]   func_rd_q;
	logic [31:0]   ret_rd_q;
	logic [31:0]   start_rd_q;
	logic          wr_en;
	logic [PW-1:0] wr_addr;
	logic [31:0]   wr_start;
	logic [31:0]   el_q;
	logic [2:0]    one_status_q;
	logic [DW-1:0] adj_prev_q;
	logic          done_q;
	result_t       one_res;
	charge_t       charge;
	logic [31:0]   charged;
	logic          t_done;
	logic          t_valid;
	logic [31:0]   t_calls;
	logic [47:0]   t_cycles;
	logic [5:0]    t_slot;
	logic [2:0]    t_status;
	logic          t_clamped;
	logic          t_last;
	logic [31:0]   t_func;
	logic [31:0]   t_elapsed;
	logic          push_ok;

	assign push_ok = sp_q < DW'(STACK_DEPTH);
	assign busy = state_q != S_IDLE;

	// read address follows the current step
	always_comb begin
		rd_addr = idx_q[PW-1:0];
		if (state_q == S_IDLE || state_q == S_RDTOP)
			rd_addr = PW'(sp_q - DW'(1));
		else if (state_q == S_SRCH)
			rd_addr = PW'(idx_q - DW'(1));
	end

	// single result of a call, a failed search or an empty flush
	always_comb begin
		one_res               = '0;
		one_res.status        = one_status_q;
		one_res.last          = 1'b1;
		one_res.depth         = 6'(sp_q);
		one_res.max_depth     = 6'(peak_q);
		one_res.total_calls   = calls_q;
		one_res.covered_calls = charged;
	end

	// stack memory: full frame write on push, start stamp write on adjust
	always_ff @(posedge clk) begin
		func_rd_q  <= func_mem[rd_addr];
		ret_rd_q   <= ret_mem[rd_addr];
		start_rd_q <= start_mem[rd_addr];
		if (state_q == S_IDLE && start && event_in.func == EV_CALL && push_ok) begin
			func_mem[sp_q[PW-1:0]]  <= event_in.target_addr;
			ret_mem[sp_q[PW-1:0]]   <= event_in.return_addr;
			start_mem[sp_q[PW-1:0]] <= event_in.cycle_stamp;
		end else if (wr_en) begin
			start_mem[wr_addr] <= wr_start;
		end
	end

	assign wr_en    = state_q == S_ADJ && rd_ok_q;
	assign wr_addr  = adj_prev_q[PW-1:0];
	assign wr_start = start_rd_q + el_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			mode_q       <= 1'b0;
			sp_q         <= '0;
			peak_q       <= '0;
			calls_q      <= '0;
			idx_q        <= '0;
			match_q      <= '0;
			rd_ok_q      <= 1'b0;
			adj_prev_q   <= '0;
			done_q       <= 1'b0;
			charge       <= '0;
			one_status_q <= ST_PUSHED;
			result_valid <= 1'b0;
		end else begin
			result_valid <= t_valid || state_q == S_ONE;
			charge.valid <= state_q == S_CLOSE;
			// hold the table's done pulse while the adjustment is still running
			done_q       <= state_q != S_WAIT && (t_done || done_q);
			if (cfg_we)
				mode_q <= cfg_wdata;
			if (t_valid) begin
				result.popped_func_addr <= t_func;
				result.elapsed        <= t_elapsed;
				result.call_count     <= t_calls;
				result.total_cycles   <= t_cycles;
				result.slot           <= t_slot;
				result.status         <= t_status;
				result.time_clamped   <= t_clamped;
				result.last           <= t_last;
				result.depth          <= 6'(sp_q);
				result.max_depth      <= 6'(peak_q);
				result.total_calls    <= calls_q;
				result.covered_calls  <= charged;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						ev_q <= event_in;
						case (event_in.func)
							EV_CALL: begin
								if (push_ok) begin
									sp_q <= sp_q + DW'(1);
									if (sp_q + DW'(1) > peak_q)
										peak_q <= sp_q + DW'(1);
									one_status_q <= ST_PUSHED;
								end else begin
									one_status_q <= ST_OVERFLOW;
								end
								calls_q <= calls_q + 32'd1;
								state_q <= S_ONE;
							end
							EV_RET: begin
								idx_q   <= sp_q;
								rd_ok_q <= 1'b0;
								state_q <= S_SRCH;
							end
							EV_FLUSH: begin
								if (sp_q == '0) begin
									one_status_q <= ST_EMPTY;
									state_q      <= S_ONE;
								end else begin
									match_q <= '0;
									state_q <= S_RDTOP;
								end
							end
							default: ;
						endcase
					end
				end
				S_ONE: begin
					result  <= one_res;
					state_q <= S_IDLE;
				end
				S_SRCH: begin
					// top down, one frame per cycle; the read data is frame idx_q
					if (rd_ok_q && ret_rd_q == ev_q.return_addr) begin
						match_q <= idx_q[PW-1:0];
						state_q <= S_RDTOP;
					end else if (idx_q == '0) begin
						one_status_q <= ST_NOMATCH;
						state_q      <= S_ONE;
					end else begin
						rd_ok_q <= 1'b1;
						idx_q   <= idx_q - DW'(1);
					end
				end
				S_RDTOP: state_q <= S_CLOSE;
				S_CLOSE: begin
					charge.func_addr <= func_rd_q;
					if (ev_q.cycle_stamp < start_rd_q) begin
						charge.elapsed <= '0;
						charge.clamped <= 1'b1;
						el_q           <= '0;
					end else begin
						charge.elapsed <= ev_q.cycle_stamp - start_rd_q;
						charge.clamped <= 1'b0;
						el_q           <= ev_q.cycle_stamp - start_rd_q;
					end
					charge.status <= (ev_q.func == EV_FLUSH ||
						PW'(sp_q - DW'(1)) == match_q) ? ST_POPPED : ST_MISALIGN;
					charge.last   <= PW'(sp_q - DW'(1)) == match_q;
					sp_q          <= sp_q - DW'(1);
					idx_q         <= '0;
					rd_ok_q       <= 1'b0;
					state_q       <= mode_q ? S_WAIT : S_ADJ;
				end
				S_ADJ: begin
					// add elapsed to every remaining frame, read then write back
					adj_prev_q <= idx_q;
					if (idx_q >= sp_q) begin
						rd_ok_q <= 1'b0;
						if (!rd_ok_q || adj_prev_q + DW'(1) >= sp_q)
							state_q <= S_WAIT;
					end else begin
						rd_ok_q <= 1'b1;
						idx_q   <= idx_q + DW'(1);
					end
				end
				S_WAIT: begin
					if (t_done || done_q) begin
						if (t_last)
							state_q <= S_IDLE;
						else
							state_q <= S_RDTOP;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	cscp_table #(.FUNC_SLOTS(FUNC_SLOTS)) u_table (
		.clk         (clk),
		.arst_n      (arst_n),
		.charge      (charge),
		.done        (t_done),
		.res_valid   (t_valid),
		.res_calls   (t_calls),
		.res_cycles  (t_cycles),
		.res_slot    (t_slot),
		.res_status  (t_status),
		.res_clamped (t_clamped),
		.res_last    (t_last),
		.res_func    (t_func),
		.res_elapsed (t_elapsed),
		.charged_q   (charged)
	);
endmodule
`default_nettype wire

// File: test/tb_call_stack_cycle_profiler.sv
// Testbench for the call stack cycle profiler: directed and random call/return traces checked against a predictor.
`timescale 1ns / 100ps
`default_nettype none

module tb_call_stack_cycle_profiler;
	import cscp_pkg::*;

	// Result store and comparison against the scoreboard's own stack and table model.
	class profile_scoreboard;
		logic [31:0] fr_func[32];
		logic [31:0] fr_ret[32];
		logic [31:0] fr_start[32];
		int          sp;
		int          peak;
		logic [31:0] fn_addr[64];
		logic [47:0] fn_cycles[64];
		logic [31:0] fn_calls[64];
		int          fn_used;
		logic [31:0] calls_seen;
		logic [31:0] calls_charged;
		bit          cumulative;
		result_t     pending[$];
		int          errors;

		function void clear();
			sp = 0;
			peak = 0;
			fn_used = 0;
			calls_seen = 0;
			calls_charged = 0;
			cumulative = 0;
			errors = 0;
			pending.delete();
		endfunction

		function result_t blank(logic [2:0] st);
			result_t r;
			r = '0;
			r.status = st;
			r.depth = sp[5:0];
			r.max_depth = peak[5:0];
			r.total_calls = calls_seen;
			r.covered_calls = calls_charged;
			return r;
		endfunction

		// Close the top frame and charge it to the function table.
		function result_t close_top(logic [31:0] stamp, logic [2:0] st);
			result_t     r;
			logic [31:0] el;
			logic [48:0] sum;
			bit          clamp;
			int          j;
			int          hit;
			sp--;
			clamp = stamp < fr_start[sp];
			el = clamp ? 32'd0 : stamp - fr_start[sp];
			if (!cumulative)
				for (j = 0; j < sp; j++)
					fr_start[j] += el;
			hit = -1;
			for (j = 0; j < fn_used; j++)
				if (hit < 0 && fn_addr[j] == fr_func[sp])
					hit = j;
			r = '0;
			if (hit >= 0) begin
				sum = fn_cycles[hit] + el;
				fn_cycles[hit] = sum > CYC_MAX ? CYC_MAX : sum[47:0];
				fn_calls[hit]++;
				calls_charged++;
			end else if (fn_used < 64) begin
				hit = fn_used;
				fn_addr[hit] = fr_func[sp];
				fn_cycles[hit] = el;
				fn_calls[hit] = 1;
				fn_used++;
				calls_charged++;
			end else begin
				st = ST_TBL_FULL;
			end
			r = blank(st);
			r.popped_func_addr = fr_func[sp];
			r.elapsed = el;
			r.time_clamped = clamp;
			if (st != ST_TBL_FULL) begin
				r.call_count = fn_calls[hit];
				r.total_cycles = fn_cycles[hit];
				r.slot = hit[5:0];
			end
			return r;
		endfunction

		// Note one accepted event and queue the results it causes.
		function void note_event(event_t ev);
			result_t r[$];
			int      i;
			int      n;
			bit      pushed;
			case (ev.func)
				EV_CALL: begin
					pushed = sp < 32;
					if (pushed) begin
						fr_func[sp] = ev.target_addr;
						fr_ret[sp] = ev.return_addr;
						fr_start[sp] = ev.cycle_stamp;
						sp++;
						if (sp > peak)
							peak = sp;
					end
					calls_seen++;
					r.push_back(blank(pushed ? ST_PUSHED : ST_OVERFLOW));
				end
				EV_RET: begin
					i = sp - 1;
					while (i >= 0 && fr_ret[i] != ev.return_addr)
						i--;
					if (i < 0) begin
						r.push_back(blank(ST_NOMATCH));
					end else begin
						while (sp > i)
							r.push_back(close_top(ev.cycle_stamp,
								(sp - 1 == i) ? ST_POPPED : ST_MISALIGN));
					end
				end
				EV_FLUSH: begin
					if (sp == 0)
						r.push_back(blank(ST_EMPTY));
					else
						while (sp > 0)
							r.push_back(close_top(ev.cycle_stamp, ST_POPPED));
				end
				default: ;
			endcase
			n = r.size();
			if (n > 0)
				r[n-1].last = 1'b1;
			foreach (r[k])
				pending.push_back(r[k]);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result %h", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected %h actual %h", want, got);
			end
		endfunction
	endclass

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	logic    busy;
	event_t  event_in = '0;
	logic    cfg_we = 1'b0;
	logic    cfg_wdata = 1'b0;
	logic    result_valid;
	result_t result;

	profile_scoreboard sb;
	bit          calm;
	logic [31:0] stamp_now;
	logic [31:0] ret_pool[8];

	call_stack_cycle_profiler dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.event_in    (event_in),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.result_valid(result_valid),
		.result      (result)
	);

	always #5 clk = ~clk;

	// Sample results at the edge; the block cannot be held off.
	always @(posedge clk)
		if (arst_n && result_valid)
			sb.check_result(result);

	// Present one event and hold it until the transfer happens.
	task automatic send_event(event_t ev);
		int gap;
		if (!calm && $urandom_range(0, 2) == 0) begin
			gap = $urandom_range(1, 12);
			start <= 1'b0;
			event_in <= '0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		event_in <= ev;
		do @(posedge clk); while (busy);
		sb.note_event(ev);
	endtask

	// Drop the request once no further event follows right away.
	task automatic release_bus();
		start <= 1'b0;
		event_in <= '0;
	endtask

	task automatic call_ev(logic [31:0] stamp, logic [31:0] ret, logic [31:0] tgt);
		event_t ev;
		ev.func = EV_CALL;
		ev.cycle_stamp = stamp;
		ev.return_addr = ret;
		ev.target_addr = tgt;
		send_event(ev);
	endtask

	task automatic ret_ev(logic [1:0] kind, logic [31:0] stamp, logic [31:0] ret);
		event_t ev;
		ev.func = kind;
		ev.cycle_stamp = stamp;
		ev.return_addr = ret;
		ev.target_addr = $urandom;
		send_event(ev);
	endtask

	// Drain outstanding results, let the block settle, then write the mode.
	task automatic set_mode(bit mode);
		release_bus();
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= mode;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.cumulative = mode;
	endtask

	// Well-formed nested traces with advancing stamps, mixed with noise.
	task automatic random_phase(int count);
		int   d;
		int   r;
		logic [31:0] tgt;
		for (int n = 0; n < count; n++) begin
			stamp_now += $urandom_range(0, 300);
			d = sb.sp;
			r = $urandom_range(0, 99);
			// a few wide targets fill the table, most reuse a small set
			tgt = ($urandom_range(0, 9) == 0) ? $urandom : 32'h1000 + $urandom_range(0, 15);
			if (r < 45 && d < 32 || d == 0 && r < 80)
				call_ev(stamp_now, ret_pool[$urandom_range(0, 7)] + d, tgt);
			else if (r < 85 && d > 0)
				ret_ev(EV_RET, stamp_now - ($urandom_range(0, 19) == 0 ? 32'd5000 : 0),
					sb.fr_ret[$urandom_range(d > 3 ? d - 3 : 0, d - 1)]);
			else if (r < 90)
				ret_ev(EV_RET, stamp_now, $urandom);
			else if (r < 95)
				ret_ev(EV_FLUSH, stamp_now, $urandom);
			else if (r < 97)
				ret_ev(2'd3, $urandom, $urandom);
			else
				call_ev($urandom, $urandom, $urandom);
		end
	endtask

	initial begin
		sb = new();
		sb.clear();
		calm = 0;
		stamp_now = 32'd100;
		foreach (ret_pool[i])
			ret_pool[i] = $urandom & 32'hFFFF_FF00;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty flush, no match, overflow, clamp, misaligned pops, extremes
		ret_ev(EV_FLUSH, 32'd0, 32'd0);
		ret_ev(EV_RET, 32'd5, 32'hFFFF_FFFF);
		ret_ev(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		call_ev(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		call_ev(32'hFFFF_FFF0, 32'd0, 32'd0);
		call_ev(32'd10, 32'h55, 32'hAAAA_AAAA);
		ret_ev(EV_RET, 32'd3, 32'h55);
		ret_ev(EV_RET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		for (int i = 0; i < 34; i++)
			call_ev(32'd1000 + i, 32'h100 + i, 32'h2000 + (i % 3));
		ret_ev(EV_RET, 32'd2000, 32'h10A);
		ret_ev(EV_FLUSH, 32'd900, 32'd0);
		set_mode(1'b1);
		call_ev(32'd50, 32'h1, 32'h7);
		call_ev(32'd60, 32'h2, 32'h8);
		ret_ev(EV_RET, 32'd70, 32'h1);

		for (int p = 0; p < 4; p++) begin
			set_mode(p[0]);
			if (p == 3)
				calm = 1;
			random_phase(55);
			ret_ev(EV_FLUSH, stamp_now, 32'd0);
		end

		release_bus();
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#100ms;
		$display("Test completed with failures");
		$finish;
	end
endmodule

`default_nettype wire
